@@ hw/rtl/owtr_pkg.sv @@
// ----------------------------------------------------------------------------
// owtr_pkg: shared types and constants of the 1-Wire temperature reader
// Transaction payloads, register layout, sequencer phase codes and the
// command bytes sent to the sensor.
// ----------------------------------------------------------------------------
package owtr_pkg;

	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int WORD_W     = 16;

	localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
	localparam logic [7:0] CMD_CONVERT_T = 8'h44;
	localparam logic [7:0] CMD_READ_SCR  = 8'hBE;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESET_LOW     = 3'd0,
		REG_WRITE0_LOW    = 3'd1,
		REG_WRITE1_LOW    = 3'd2,
		REG_WRITE_RELEASE = 3'd3,
		REG_READ_LOW      = 3'd4,
		REG_READ_SAMPLE   = 3'd5,
		REG_READ_REST     = 3'd6,
		REG_CONVERT_WAIT  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [9:0]  reset_low_us;
		logic [7:0]  write0_low_us;
		logic [7:0]  write1_low_us;
		logic [7:0]  write_release_us;
		logic [7:0]  read_low_us;
		logic [7:0]  read_sample_us;
		logic [7:0]  read_rest_us;
		logic [19:0] convert_wait_us;
	} cfg_t;

	localparam logic [9:0]  RST_RESET_LOW     = 10'd480;
	localparam logic [7:0]  RST_WRITE0_LOW    = 8'd65;
	localparam logic [7:0]  RST_WRITE1_LOW    = 8'd10;
	localparam logic [7:0]  RST_WRITE_RELEASE = 8'd61;
	localparam logic [7:0]  RST_READ_LOW      = 8'd2;
	localparam logic [7:0]  RST_READ_SAMPLE   = 8'd11;
	localparam logic [7:0]  RST_READ_REST     = 8'd48;
	localparam logic [19:0] RST_CONVERT_WAIT  = 20'd750000;

	typedef struct packed {
		logic cmd;
		logic line_level;
	} tick_t;

	typedef struct packed {
		logic              drive_low;
		logic              busy_res;
		logic              done_res;
		logic [WORD_W-1:0] temperature_word;
	} result_t;

	typedef enum logic [9:0] {
		PH_IDLE  = 10'b00_0000_0001,
		PH_RST   = 10'b00_0000_0010,
		PH_PRES  = 10'b00_0000_0100,
		PH_WLOW  = 10'b00_0000_1000,
		PH_WREL  = 10'b00_0001_0000,
		PH_GAP   = 10'b00_0010_0000,
		PH_CONV  = 10'b00_0100_0000,
		PH_RLOW  = 10'b00_1000_0000,
		PH_RREL  = 10'b01_0000_0000,
		PH_RREST = 10'b10_0000_0000
	} phase_t;

endpackage

@@ hw/rtl/owtr_cfg.sv @@
// ----------------------------------------------------------------------------
// owtr_cfg: timing register file
// Holds the eight bus timing registers, written through the plain write port.
// ----------------------------------------------------------------------------
module owtr_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [owtr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [owtr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output owtr_pkg::cfg_t                      cfg
);

	owtr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_us     <= owtr_pkg::RST_RESET_LOW;
			cfg_q.write0_low_us    <= owtr_pkg::RST_WRITE0_LOW;
			cfg_q.write1_low_us    <= owtr_pkg::RST_WRITE1_LOW;
			cfg_q.write_release_us <= owtr_pkg::RST_WRITE_RELEASE;
			cfg_q.read_low_us      <= owtr_pkg::RST_READ_LOW;
			cfg_q.read_sample_us   <= owtr_pkg::RST_READ_SAMPLE;
			cfg_q.read_rest_us     <= owtr_pkg::RST_READ_REST;
			cfg_q.convert_wait_us  <= owtr_pkg::RST_CONVERT_WAIT;
		end else if (cfg_we) begin
			unique case (owtr_pkg::cfg_reg_t'(cfg_index))
				owtr_pkg::REG_RESET_LOW:     cfg_q.reset_low_us     <= cfg_data[9:0];
				owtr_pkg::REG_WRITE0_LOW:    cfg_q.write0_low_us    <= cfg_data[7:0];
				owtr_pkg::REG_WRITE1_LOW:    cfg_q.write1_low_us    <= cfg_data[7:0];
				owtr_pkg::REG_WRITE_RELEASE: cfg_q.write_release_us <= cfg_data[7:0];
				owtr_pkg::REG_READ_LOW:      cfg_q.read_low_us      <= cfg_data[7:0];
				owtr_pkg::REG_READ_SAMPLE:   cfg_q.read_sample_us   <= cfg_data[7:0];
				owtr_pkg::REG_READ_REST:     cfg_q.read_rest_us     <= cfg_data[7:0];
				owtr_pkg::REG_CONVERT_WAIT:  cfg_q.convert_wait_us  <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hw/rtl/owtr_seq.sv @@
// ----------------------------------------------------------------------------
// owtr_seq: bus sequencer
// Phase, slot timer and bit counters; one tick is applied per step and the
// tick's result is produced combinationally from the current state.
// ----------------------------------------------------------------------------
module owtr_seq #(
	parameter int TIMER_BITS = 20,
	parameter int READ_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  owtr_pkg::tick_t     tick,
	input  owtr_pkg::cfg_t      cfg,
	output owtr_pkg::result_t   res
);

	localparam int BC_W = $clog2(READ_BITS + 1);

	owtr_pkg::phase_t                 phase_q, ph_cur, ph_nxt;
	logic [TIMER_BITS-1:0]            timer_q, tm_cur, tm_nxt;
	logic [BC_W-1:0]                  bc_q, bc_cur, bc_nxt, bc_inc;
	logic                             ci_q, ci_cur, ci_nxt;
	logic                             sp_q, sp_cur, sp_nxt;
	logic [owtr_pkg::WORD_W-1:0]      shift_q, shift_nxt;
	logic                             done;

	function automatic logic [TIMER_BITS-1:0] load_time(input logic [31:0] v);
		logic [TIMER_BITS-1:0] t;
		t = v[TIMER_BITS-1:0];
		return (t == '0) ? TIMER_BITS'(1) : t;
	endfunction

	function automatic logic write_bit(input logic idx, input logic pass,
			input logic [2:0] pos);
		logic [7:0] cmd_byte;
		cmd_byte = !idx ? owtr_pkg::CMD_SKIP_ROM :
			(pass ? owtr_pkg::CMD_READ_SCR : owtr_pkg::CMD_CONVERT_T);
		return cmd_byte[pos];
	endfunction

	function automatic logic [TIMER_BITS-1:0] write_time(input owtr_pkg::cfg_t c,
			input logic b);
		return b ? load_time(32'(c.write1_low_us)) : load_time(32'(c.write0_low_us));
	endfunction

	always_comb begin
		ph_cur = phase_q;
		tm_cur = timer_q;
		bc_cur = bc_q;
		ci_cur = ci_q;
		sp_cur = sp_q;
		if (phase_q == owtr_pkg::PH_IDLE && tick.cmd) begin
			ph_cur = owtr_pkg::PH_RST;
			tm_cur = load_time(32'(cfg.reset_low_us));
			bc_cur = '0;
			ci_cur = 1'b0;
			sp_cur = 1'b0;
		end

		ph_nxt    = ph_cur;
		tm_nxt    = (tm_cur != '0) ? tm_cur - TIMER_BITS'(1) : '0;
		bc_nxt    = bc_cur;
		ci_nxt    = ci_cur;
		sp_nxt    = sp_cur;
		shift_nxt = shift_q;
		bc_inc    = bc_cur + BC_W'(1);
		done      = 1'b0;

		if (ph_cur != owtr_pkg::PH_IDLE && tm_nxt == '0) begin
			unique case (ph_cur)
				owtr_pkg::PH_RST: begin
					ph_nxt = owtr_pkg::PH_PRES;
					tm_nxt = load_time(32'(cfg.reset_low_us));
				end
				owtr_pkg::PH_PRES: begin
					ci_nxt = 1'b0;
					bc_nxt = '0;
					ph_nxt = owtr_pkg::PH_WLOW;
					tm_nxt = write_time(cfg, write_bit(1'b0, sp_cur, 3'd0));
				end
				owtr_pkg::PH_WLOW: begin
					ph_nxt = owtr_pkg::PH_WREL;
					tm_nxt = load_time(32'(cfg.write_release_us));
				end
				owtr_pkg::PH_WREL: begin
					bc_nxt = bc_inc;
					if (32'(bc_inc) < 32'd8) begin
						ph_nxt = owtr_pkg::PH_WLOW;
						tm_nxt = write_time(cfg, write_bit(ci_cur, sp_cur, bc_inc[2:0]));
					end else if (!ci_cur) begin
						ph_nxt = owtr_pkg::PH_GAP;
						tm_nxt = TIMER_BITS'(1);
					end else if (!sp_cur) begin
						ph_nxt = owtr_pkg::PH_CONV;
						tm_nxt = load_time(32'(cfg.convert_wait_us));
					end else begin
						bc_nxt    = '0;
						shift_nxt = '0;
						ph_nxt    = owtr_pkg::PH_RLOW;
						tm_nxt    = load_time(32'(cfg.read_low_us));
					end
				end
				owtr_pkg::PH_GAP: begin
					ci_nxt = 1'b1;
					bc_nxt = '0;
					ph_nxt = owtr_pkg::PH_WLOW;
					tm_nxt = write_time(cfg, write_bit(1'b1, sp_cur, 3'd0));
				end
				owtr_pkg::PH_CONV: begin
					sp_nxt = 1'b1;
					ph_nxt = owtr_pkg::PH_RST;
					tm_nxt = load_time(32'(cfg.reset_low_us));
				end
				owtr_pkg::PH_RLOW: begin
					ph_nxt = owtr_pkg::PH_RREL;
					tm_nxt = load_time(32'(cfg.read_sample_us));
				end
				owtr_pkg::PH_RREL: begin
					if (tick.line_level && 32'(bc_cur) < 32'(owtr_pkg::WORD_W))
						shift_nxt[bc_cur[3:0]] = 1'b1;
					ph_nxt = owtr_pkg::PH_RREST;
					tm_nxt = load_time(32'(cfg.read_rest_us));
				end
				owtr_pkg::PH_RREST: begin
					if (bc_inc >= BC_W'(READ_BITS)) begin
						done   = 1'b1;
						ph_nxt = owtr_pkg::PH_IDLE;
						tm_nxt = '0;
						bc_nxt = '0;
						ci_nxt = 1'b0;
						sp_nxt = 1'b0;
					end else begin
						bc_nxt = bc_inc;
						ph_nxt = owtr_pkg::PH_RLOW;
						tm_nxt = load_time(32'(cfg.read_low_us));
					end
				end
				default: begin
					ph_nxt = owtr_pkg::PH_IDLE;
					tm_nxt = '0;
				end
			endcase
		end else if (ph_cur == owtr_pkg::PH_IDLE) begin
			tm_nxt = tm_cur;
		end

		res.drive_low = (ph_cur == owtr_pkg::PH_RST) || (ph_cur == owtr_pkg::PH_WLOW) ||
			(ph_cur == owtr_pkg::PH_RLOW);
		res.busy_res         = (ph_cur != owtr_pkg::PH_IDLE);
		res.done_res         = done;
		res.temperature_word = shift_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owtr_pkg::PH_IDLE;
			timer_q <= '0;
			bc_q    <= '0;
			ci_q    <= 1'b0;
			sp_q    <= 1'b0;
			shift_q <= '0;
		end else if (step) begin
			phase_q <= ph_nxt;
			timer_q <= tm_nxt;
			bc_q    <= bc_nxt;
			ci_q    <= ci_nxt;
			sp_q    <= sp_nxt;
			shift_q <= shift_nxt;
		end
	end

endmodule

@@ hw/rtl/one_wire_temperature_reader.sv @@
// One tick transaction is taken every clock cycle unless a stalled result
// register holds it back, and each gives exactly one result transaction; each
// tick stands for one microsecond of bus time. A tick passes an input register,
// then the sequencer updates its state and loads the result register together
// on the same step, and the result register stalling only holds back new ticks
// once the input register is also full. Bus timing is counted in ticks, not
// clock cycles, so the timing registers are in microseconds of tick stream.
// ----------------------------------------------------------------------------
// one_wire_temperature_reader: 1-Wire master reading a temperature sensor
// Issues reset, Skip ROM, Convert T, waits, then reset, Skip ROM, Read
// Scratchpad and samples the temperature word LSB first.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader #(
	parameter int TIMER_BITS = 20,
	parameter int READ_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick_valid,
	output logic                            tick_ready,
	input  owtr_pkg::tick_t                 tick,
	output logic                            result_valid,
	input  logic                            result_ready,
	output owtr_pkg::result_t               result,
	input  logic                            cfg_we,
	input  logic [owtr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [owtr_pkg::CFG_DATA_W-1:0] cfg_data
);

	owtr_pkg::cfg_t    cfg;
	owtr_pkg::tick_t   tick_s1;
	logic              tick_vld_s1;
	owtr_pkg::result_t res;
	owtr_pkg::result_t result_q;
	logic              result_vld_q;
	logic              step;

	assign step       = tick_vld_s1 && (!result_vld_q || result_ready);
	assign tick_ready = !tick_vld_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_vld_s1 <= 1'b0;
		end else if (tick_ready) begin
			tick_vld_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			tick_s1 <= tick;
		end
	end

	owtr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owtr_seq #(
		.TIMER_BITS (TIMER_BITS),
		.READ_BITS  (READ_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.tick   (tick_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_vld_q <= 1'b0;
		end else if (step) begin
			result_vld_q <= 1'b1;
		end else if (result_ready) begin
			result_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= res;
		end
	end

	assign result_valid = result_vld_q;
	assign result       = result_q;

endmodule

@@ hw/rtl/owtr_chk.sv @@
// ----------------------------------------------------------------------------
// owtr_chk: port checker for the 1-Wire temperature reader
// Watches the result channel for handshake and bus-state consistency.
// ----------------------------------------------------------------------------
module owtr_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input owtr_pkg::result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result transaction changed while stalled");

	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.busy_res |-> !result.drive_low)
		else $error("bus driven low while idle");

	a_idle_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.busy_res |-> !result.done_res)
		else $error("done pulse while idle");

	a_done_released: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> result.busy_res && !result.drive_low)
		else $error("done outside the final released read time");

endmodule

bind one_wire_temperature_reader owtr_chk u_owtr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

@@ bench/tb_one_wire_temperature_reader.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_wire_temperature_reader: self-checking bench for the 1-Wire reader
// Streams microsecond ticks through the tick channel, predicts every result
// transaction with an in-bench sequencer model and compares it field by field.
// Covers zero and masked timings, starts while busy, all-ones and all-zeros
// reads, random timing sets, back pressure and a final stretch with no idling.
// ----------------------------------------------------------------------------
module tb_one_wire_temperature_reader;

	localparam int TIMER_BITS  = 20;
	localparam int READ_BITS   = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_TICKS = 850;
	localparam longint LIMIT_NS = 64'd5_000_000;

	localparam int LINE_LOW    = 0;
	localparam int LINE_HIGH   = 1;
	localparam int LINE_RANDOM = 2;

	logic                            clk;
	logic                            arst_n       = 1'b0;
	logic                            tick_valid   = 1'b0;
	logic                            tick_ready;
	owtr_pkg::tick_t                 tick         = '0;
	logic                            result_valid;
	logic                            result_ready = 1'b0;
	owtr_pkg::result_t               result;
	logic                            cfg_we       = 1'b0;
	logic [owtr_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [owtr_pkg::CFG_DATA_W-1:0] cfg_data     = '0;

	// sequencer model state
	owtr_pkg::cfg_t   sensor_cfg;
	owtr_pkg::phase_t seq_phase  = owtr_pkg::PH_IDLE;
	logic [19:0]      slot_left  = '0;
	logic [4:0]       bit_cnt    = '0;
	logic [1:0]       cmd_slot   = '0;
	logic             second_pass = 1'b0;
	logic [15:0]      shift_word = '0;

	owtr_pkg::tick_t   tick_queue[$];
	owtr_pkg::result_t due_outputs[$];
	int      ticks_sent    = 0;
	int      ticks_taken   = 0;
	int      results_seen  = 0;
	bit      mismatch_seen = 1'b0;
	bit      tick_accepted = 1'b0;
	bit      idling_on     = 1'b1;
	int      hold_asks     = 0;
	int      holds_served  = 0;
	int      hold_left     = 0;
	int      stall_left    = 0;
	int      gap_left      = 0;

	one_wire_temperature_reader #(
		.TIMER_BITS(TIMER_BITS),
		.READ_BITS (READ_BITS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_valid  (tick_valid),
		.tick_ready  (tick_ready),
		.tick        (tick),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic enter_phase(input owtr_pkg::phase_t p, input logic [19:0] dur);
		seq_phase = p;
		slot_left = (dur == '0) ? 20'd1 : dur;
	endtask

	task automatic next_write_bit();
		logic [7:0] cmd_byte;
		if (cmd_slot == 2'd0)
			cmd_byte = owtr_pkg::CMD_SKIP_ROM;
		else if (second_pass)
			cmd_byte = owtr_pkg::CMD_READ_SCR;
		else
			cmd_byte = owtr_pkg::CMD_CONVERT_T;
		if (cmd_byte[bit_cnt[2:0]])
			enter_phase(owtr_pkg::PH_WLOW, {12'd0, sensor_cfg.write1_low_us});
		else
			enter_phase(owtr_pkg::PH_WLOW, {12'd0, sensor_cfg.write0_low_us});
	endtask

	task automatic advance_phase(input logic line, output logic finished);
		finished = 1'b0;
		case (seq_phase)
			owtr_pkg::PH_RST:
				enter_phase(owtr_pkg::PH_PRES, {10'd0, sensor_cfg.reset_low_us});
			owtr_pkg::PH_PRES: begin
				cmd_slot = 2'd0;
				bit_cnt = '0;
				next_write_bit();
			end
			owtr_pkg::PH_WLOW:
				enter_phase(owtr_pkg::PH_WREL, {12'd0, sensor_cfg.write_release_us});
			owtr_pkg::PH_WREL: begin
				bit_cnt = bit_cnt + 5'd1;
				if (bit_cnt < 5'd8) begin
					next_write_bit();
				end else if (cmd_slot == 2'd0) begin
					enter_phase(owtr_pkg::PH_GAP, 20'd1);
				end else if (!second_pass) begin
					enter_phase(owtr_pkg::PH_CONV, sensor_cfg.convert_wait_us);
				end else begin
					bit_cnt = '0;
					shift_word = '0;
					enter_phase(owtr_pkg::PH_RLOW, {12'd0, sensor_cfg.read_low_us});
				end
			end
			owtr_pkg::PH_GAP: begin
				cmd_slot = 2'd1;
				bit_cnt = '0;
				next_write_bit();
			end
			owtr_pkg::PH_CONV: begin
				second_pass = 1'b1;
				enter_phase(owtr_pkg::PH_RST, {10'd0, sensor_cfg.reset_low_us});
			end
			owtr_pkg::PH_RLOW:
				enter_phase(owtr_pkg::PH_RREL, {12'd0, sensor_cfg.read_sample_us});
			owtr_pkg::PH_RREL: begin
				if (line && bit_cnt < 5'd16)
					shift_word[bit_cnt[3:0]] = 1'b1;
				enter_phase(owtr_pkg::PH_RREST, {12'd0, sensor_cfg.read_rest_us});
			end
			owtr_pkg::PH_RREST: begin
				bit_cnt = bit_cnt + 5'd1;
				if (bit_cnt >= 5'(READ_BITS)) begin
					seq_phase = owtr_pkg::PH_IDLE;
					slot_left = '0;
					bit_cnt = '0;
					cmd_slot = '0;
					second_pass = 1'b0;
					finished = 1'b1;
				end else begin
					enter_phase(owtr_pkg::PH_RLOW, {12'd0, sensor_cfg.read_low_us});
				end
			end
			default: begin
				seq_phase = owtr_pkg::PH_IDLE;
				slot_left = '0;
			end
		endcase
	endtask

	task automatic sequence_tick(input owtr_pkg::tick_t t, output owtr_pkg::result_t r);
		logic finished;
		finished = 1'b0;
		if (seq_phase == owtr_pkg::PH_IDLE && t.cmd) begin
			second_pass = 1'b0;
			cmd_slot = '0;
			bit_cnt = '0;
			enter_phase(owtr_pkg::PH_RST, {10'd0, sensor_cfg.reset_low_us});
		end
		r.drive_low = (seq_phase == owtr_pkg::PH_RST || seq_phase == owtr_pkg::PH_WLOW ||
			seq_phase == owtr_pkg::PH_RLOW);
		r.busy_res = (seq_phase != owtr_pkg::PH_IDLE);
		if (seq_phase != owtr_pkg::PH_IDLE) begin
			if (slot_left != '0)
				slot_left = slot_left - 20'd1;
			if (slot_left == '0)
				advance_phase(t.line_level, finished);
		end
		r.done_res = finished;
		r.temperature_word = shift_word;
	endtask

	// result check and tick prediction
	always @(posedge clk) begin : monitor
		owtr_pkg::result_t want;
		owtr_pkg::result_t got;
		tick_accepted = tick_valid && tick_ready;
		if (result_valid && result_ready) begin
			results_seen++;
			got = result;
			if (due_outputs.size() == 0) begin
				$error("result transaction with no tick outstanding");
				mismatch_seen = 1'b1;
			end else begin
				want = due_outputs.pop_front();
				if (got.drive_low !== want.drive_low) begin
					$error("drive_low: expected %0b, got %0b", want.drive_low, got.drive_low);
					mismatch_seen = 1'b1;
				end
				if (got.busy_res !== want.busy_res) begin
					$error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
					mismatch_seen = 1'b1;
				end
				if (got.done_res !== want.done_res) begin
					$error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
					mismatch_seen = 1'b1;
				end
				if (got.temperature_word !== want.temperature_word) begin
					$error("temperature_word: expected %04h, got %04h",
						want.temperature_word, got.temperature_word);
					mismatch_seen = 1'b1;
				end
			end
		end
		if (tick_accepted) begin
			sequence_tick(tick, want);
			due_outputs.push_back(want);
			ticks_taken++;
		end
	end

	always @(negedge clk) begin : driver
		if (!tick_valid || tick_accepted) begin
			if (gap_left > 0) begin
				gap_left--;
				tick_valid <= 1'b0;
			end else if (idling_on && tick_queue.size() != 0 && $urandom_range(0, 11) == 0) begin
				gap_left = $urandom_range(0, 12);
				tick_valid <= 1'b0;
			end else if (tick_queue.size() != 0) begin
				tick <= tick_queue.pop_front();
				tick_valid <= 1'b1;
			end else begin
				tick_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (holds_served != hold_asks) begin
			holds_served++;
			hold_left = HOLD_CYCLES - 1;
			result_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(0, 12);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	function automatic logic line_for(input int mode);
		if (mode == LINE_LOW)
			return 1'b0;
		if (mode == LINE_HIGH)
			return 1'b1;
		return 1'($urandom_range(0, 1));
	endfunction

	// short time in the low bits, now and then with high bits above the widths of the registers it feeds
	function automatic logic [19:0] pick_time();
		if ($urandom_range(0, 31) == 0)
			return {10'($urandom()), 10'($urandom_range(0, 5))};
		return 20'($urandom_range(0, 5));
	endfunction

	function automatic logic [19:0] pick_wait();
		if ($urandom_range(0, 7) == 0)
			return 20'($urandom_range(0, 400));
		return 20'($urandom_range(0, 6));
	endfunction

	task automatic push_tick(input logic start, input logic line);
		owtr_pkg::tick_t t;
		t.cmd = start;
		t.line_level = line;
		tick_queue.push_back(t);
		ticks_sent++;
	endtask

	task automatic write_reg(input owtr_pkg::cfg_reg_t idx, input logic [19:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			owtr_pkg::REG_RESET_LOW:     sensor_cfg.reset_low_us = data[9:0];
			owtr_pkg::REG_WRITE0_LOW:    sensor_cfg.write0_low_us = data[7:0];
			owtr_pkg::REG_WRITE1_LOW:    sensor_cfg.write1_low_us = data[7:0];
			owtr_pkg::REG_WRITE_RELEASE: sensor_cfg.write_release_us = data[7:0];
			owtr_pkg::REG_READ_LOW:      sensor_cfg.read_low_us = data[7:0];
			owtr_pkg::REG_READ_SAMPLE:   sensor_cfg.read_sample_us = data[7:0];
			owtr_pkg::REG_READ_REST:     sensor_cfg.read_rest_us = data[7:0];
			owtr_pkg::REG_CONVERT_WAIT:  sensor_cfg.convert_wait_us = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_timing(input logic [19:0] rst_low, w0_low, w1_low, w_rel,
		r_low, r_sample, r_rest, conv);
		write_reg(owtr_pkg::REG_RESET_LOW, rst_low);
		write_reg(owtr_pkg::REG_WRITE0_LOW, w0_low);
		write_reg(owtr_pkg::REG_WRITE1_LOW, w1_low);
		write_reg(owtr_pkg::REG_WRITE_RELEASE, w_rel);
		write_reg(owtr_pkg::REG_READ_LOW, r_low);
		write_reg(owtr_pkg::REG_READ_SAMPLE, r_sample);
		write_reg(owtr_pkg::REG_READ_REST, r_rest);
		write_reg(owtr_pkg::REG_CONVERT_WAIT, conv);
	endtask

	// keep ticks flowing until the sequencer is idle and every result is back
	task automatic finish_sequence(input int line_mode);
		while (seq_phase != owtr_pkg::PH_IDLE || ticks_taken != ticks_sent) begin
			wait ((seq_phase != owtr_pkg::PH_IDLE && ticks_sent - ticks_taken < 8) ||
				(seq_phase == owtr_pkg::PH_IDLE && ticks_taken == ticks_sent));
			if (seq_phase != owtr_pkg::PH_IDLE)
				repeat (32) push_tick(1'b0, line_for(line_mode));
		end
		wait (results_seen >= ticks_taken);
	endtask

	initial begin : stimulus
		int random_base;
		int body;
		int phase_no;
		sensor_cfg = '{owtr_pkg::RST_RESET_LOW, owtr_pkg::RST_WRITE0_LOW,
			owtr_pkg::RST_WRITE1_LOW, owtr_pkg::RST_WRITE_RELEASE,
			owtr_pkg::RST_READ_LOW, owtr_pkg::RST_READ_SAMPLE,
			owtr_pkg::RST_READ_REST, owtr_pkg::RST_CONVERT_WAIT};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle ticks under reset timing
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);
		finish_sequence(LINE_LOW);

		// zero timings count as one tick; starts while busy are ignored
		write_timing('0, '0, '0, '0, '0, '0, '0, '0);
		push_tick(1'b1, 1'b1);
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b1, 1'b1);
		push_tick(1'b0, 1'b0);
		push_tick(1'b1, 1'b0);
		finish_sequence(LINE_HIGH);

		// data above the register widths, one value masking to zero
		write_timing(20'hFFC02, 20'hFFF01, 20'h00100, 20'hFFF01,
			20'h00101, 20'h00102, 20'h00101, 20'h00003);
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b1);
		finish_sequence(LINE_LOW);

		random_base = ticks_sent;
		phase_no = 0;
		while (ticks_sent - random_base < RANDOM_TICKS) begin
			write_timing(pick_time(), pick_time(), pick_time(), pick_time(),
				pick_time(), pick_time(), pick_time(), pick_wait());
			body = (phase_no == 0) ? 450 : $urandom_range(60, 240);
			push_tick(1'b1, line_for(LINE_RANDOM));
			repeat (body - 1)
				push_tick(1'($urandom_range(0, 15) == 0), line_for(LINE_RANDOM));
			if (phase_no == 0) begin
				hold_asks++;
				wait (ticks_taken == ticks_sent && results_seen >= ticks_taken);
				repeat (100)
					push_tick(1'($urandom_range(0, 15) == 0), line_for(LINE_RANDOM));
			end
			finish_sequence(LINE_RANDOM);
			phase_no++;
		end

		// short timings with a longer conversion wait, no idling
		idling_on = 1'b0;
		write_timing(20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd150);
		push_tick(1'b1, 1'b0);
		finish_sequence(LINE_RANDOM);

		repeat (8) @(posedge clk);
		if (due_outputs.size() != 0) begin
			$error("%0d result transactions never arrived", due_outputs.size());
			mismatch_seen = 1'b1;
		end
		if (!mismatch_seen)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/owtr_pkg.sv
hw/rtl/owtr_cfg.sv
hw/rtl/owtr_seq.sv
hw/rtl/one_wire_temperature_reader.sv
hw/rtl/owtr_chk.sv
bench/tb_one_wire_temperature_reader.sv
